// ===== hw/rtl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg: shared types and constants of the source token scanner
// Request and response payloads, the response burst handed from the lexer
// to the response queue, token kinds, error bits and lookahead helpers.
// ----------------------------------------------------------------------------
package stsc_pkg;

   // one source byte or an end marker
   typedef struct packed {
      logic [7:0] source_char;
      logic       source_end;
   } req_type;

   // one emitted token
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] lexeme_start;
      logic [15:0] lexeme_length;
      logic [15:0] line_number;
      logic [4:0]  error_bits;
      logic        any_error;
      logic        last_of_run;
   } rsp_type;

   // up to two tokens caused by one request, first in order first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } burst_type;

   // token kinds
   localparam logic [4:0] KIND_EOF         = 5'd0;
   localparam logic [4:0] KIND_LPAREN      = 5'd1;
   localparam logic [4:0] KIND_RPAREN      = 5'd2;
   localparam logic [4:0] KIND_LBRACE      = 5'd3;
   localparam logic [4:0] KIND_RBRACE      = 5'd4;
   localparam logic [4:0] KIND_BRACKETS    = 5'd5;
   localparam logic [4:0] KIND_LBRACKET    = 5'd6;
   localparam logic [4:0] KIND_RBRACKET    = 5'd7;
   localparam logic [4:0] KIND_COMMA       = 5'd8;
   localparam logic [4:0] KIND_STAR        = 5'd9;
   localparam logic [4:0] KIND_SEMI        = 5'd10;
   localparam logic [4:0] KIND_AMP         = 5'd11;
   localparam logic [4:0] KIND_DOT         = 5'd12;
   localparam logic [4:0] KIND_LESS_EQ     = 5'd13;
   localparam logic [4:0] KIND_LESS        = 5'd14;
   localparam logic [4:0] KIND_GREATER_EQ  = 5'd15;
   localparam logic [4:0] KIND_GREATER     = 5'd16;
   localparam logic [4:0] KIND_BANG_EQ     = 5'd17;
   localparam logic [4:0] KIND_BANG        = 5'd18;
   localparam logic [4:0] KIND_EQ_EQ       = 5'd19;
   localparam logic [4:0] KIND_EQ          = 5'd20;
   localparam logic [4:0] KIND_PLUS_PLUS   = 5'd21;
   localparam logic [4:0] KIND_PLUS        = 5'd22;
   localparam logic [4:0] KIND_MINUS_MINUS = 5'd23;
   localparam logic [4:0] KIND_MINUS       = 5'd24;
   localparam logic [4:0] KIND_COMMENT     = 5'd25;
   localparam logic [4:0] KIND_SLASH       = 5'd26;
   localparam logic [4:0] KIND_STRING      = 5'd27;
   localparam logic [4:0] KIND_CHAR        = 5'd28;
   localparam logic [4:0] KIND_UNKNOWN     = 5'd29;

   // error flags
   localparam logic [4:0] ERR_MULTILINE     = 5'b00001;
   localparam logic [4:0] ERR_UNTERM_STRING = 5'b00010;
   localparam logic [4:0] ERR_UNTERM_CHAR   = 5'b00100;
   localparam logic [4:0] ERR_CHAR_LONG     = 5'b01000;
   localparam logic [4:0] ERR_UNKNOWN       = 5'b10000;

   // longest legal char literal, quotes included
   localparam logic [16:0] CHAR_LIMIT = 17'd3;

   // kind of a lookahead character when no pair follows
   function automatic logic [4:0] single_kind(input logic [7:0] lead);
      logic [4:0] kind;
      case (lead)
         "[":     kind = KIND_LBRACKET;
         "<":     kind = KIND_LESS;
         ">":     kind = KIND_GREATER;
         "!":     kind = KIND_BANG;
         "=":     kind = KIND_EQ;
         "+":     kind = KIND_PLUS;
         "-":     kind = KIND_MINUS;
         default: kind = KIND_SLASH;
      endcase
      return kind;
   endfunction

   // kind of a two-character token, KIND_EOF when the pair does not form
   function automatic logic [4:0] pair_kind(input logic [7:0] lead,
                                            input logic [7:0] c);
      logic [4:0] kind;
      kind = KIND_EOF;
      case (lead)
         "[":     if (c == "]") kind = KIND_BRACKETS;
         "<":     if (c == "=") kind = KIND_LESS_EQ;
         ">":     if (c == "=") kind = KIND_GREATER_EQ;
         "!":     if (c == "=") kind = KIND_BANG_EQ;
         "=":     if (c == "=") kind = KIND_EQ_EQ;
         "+":     if (c == "+") kind = KIND_PLUS_PLUS;
         "-":     if (c == "-") kind = KIND_MINUS_MINUS;
         "/":     if (c == "/") kind = KIND_COMMENT;
         default: kind = KIND_EOF;
      endcase
      return kind;
   endfunction

endpackage

// ===== hw/rtl/stsc_lexer.sv =====
// ----------------------------------------------------------------------------
// stsc_lexer: scanner state and per-byte token logic
// Holds the scan mode, lookahead character, position, line count and token
// bookkeeping, and works out the zero, one or two tokens a request causes.
// ----------------------------------------------------------------------------
module stsc_lexer #(
   parameter int unsigned POSITION_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  stsc_pkg::req_type   req,
   output stsc_pkg::burst_type burst
);
   import stsc_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LOOK,
      MODE_COMMENT,
      MODE_STRING,
      MODE_STRTAIL,
      MODE_CHAR
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic [7:0]                lead_ff, lead_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [15:0]               line_ff, line_in;
   logic                      seen_ff, seen_in;
   logic [4:0]                pend_ff, pend_in;
   logic [15:0]               len_ff, len_in;

   logic [POSITION_WIDTH-1:0] pos_inc;
   logic [31:0]               pos_wide;
   logic [31:0]               start_wide;
   logic [15:0]               pos16;
   logic [15:0]               start16;
   logic [15:0]               len_grow;
   logic [4:0]                pair;
   logic [7:0]                c;
   logic                      scan_byte;

   logic                      a_valid, b_valid;
   logic [4:0]                a_kind, b_kind;
   logic [15:0]               a_len, b_len, b_start;
   logic [4:0]                a_err, b_err;
   logic                      seen_a;
   rsp_type                   rsp_a, rsp_b;

   // helpers shared by all modes
   assign c          = req.source_char;
   assign pos_inc    = pos_ff + 1'b1;
   assign pos_wide   = 32'(pos_ff);
   assign start_wide = 32'(start_ff);
   assign pos16      = pos_wide[15:0];
   assign start16    = start_wide[15:0];
   assign len_grow   = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
   assign pair       = pair_kind(lead_ff, c);

   // next state and tokens for one request
   always_comb begin
      mode_in   = mode_ff;
      lead_in   = lead_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      a_valid   = 1'b0;
      a_kind    = KIND_EOF;
      a_len     = len_ff;
      a_err     = '0;
      b_valid   = 1'b0;
      b_kind    = KIND_EOF;
      b_start   = pos16;
      b_len     = 16'd1;
      b_err     = '0;
      scan_byte = 1'b0;

      if (req.source_end) begin
         // flush a token in progress, then end of file
         a_valid = 1'b1;
         case (mode_ff)
            MODE_LOOK: a_kind = single_kind(lead_ff);
            MODE_COMMENT: a_kind = KIND_COMMENT;
            MODE_STRING, MODE_STRTAIL: begin
               a_kind = KIND_STRING;
               a_err  = pend_ff | ERR_UNTERM_STRING;
            end
            MODE_CHAR: begin
               a_kind = KIND_CHAR;
               a_err  = pend_ff | ERR_UNTERM_CHAR;
               if (({1'b0, len_ff} + 17'd1) > CHAR_LIMIT) a_err = a_err | ERR_CHAR_LONG;
            end
            default: a_valid = 1'b0;
         endcase
         mode_in = MODE_IDLE;
         pend_in = '0;
         b_valid = 1'b1;
         b_kind  = KIND_EOF;
         b_start = pos16;
         b_len   = 16'd0;
      end else begin
         case (mode_ff)
            // second character of a possible pair
            MODE_LOOK: begin
               if (pair == KIND_COMMENT) begin
                  pos_in  = pos_inc;
                  len_in  = len_grow;
                  mode_in = MODE_COMMENT;
               end else if (pair != KIND_EOF) begin
                  pos_in  = pos_inc;
                  len_in  = len_grow;
                  a_valid = 1'b1;
                  a_kind  = pair;
                  a_len   = len_grow;
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end else begin
                  a_valid   = 1'b1;
                  a_kind    = single_kind(lead_ff);
                  mode_in   = MODE_IDLE;
                  pend_in   = '0;
                  scan_byte = 1'b1;
               end
            end
            // comment body up to the newline
            MODE_COMMENT: begin
               if (c == "\n") begin
                  a_valid   = 1'b1;
                  a_kind    = KIND_COMMENT;
                  mode_in   = MODE_IDLE;
                  pend_in   = '0;
                  scan_byte = 1'b1;
               end else begin
                  pos_in = pos_inc;
                  len_in = len_grow;
               end
            end
            // string body
            MODE_STRING: begin
               pos_in = pos_inc;
               len_in = len_grow;
               if (c == "\"") begin
                  a_valid = 1'b1;
                  a_kind  = KIND_STRING;
                  a_len   = len_grow;
                  a_err   = pend_ff;
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end else if (c == "\n") begin
                  pend_in = pend_ff | ERR_MULTILINE;
                  mode_in = MODE_STRTAIL;
               end
            end
            // byte after a newline in a string ends it
            MODE_STRTAIL: begin
               pos_in  = pos_inc;
               len_in  = len_grow;
               a_valid = 1'b1;
               a_kind  = KIND_STRING;
               a_len   = len_grow;
               a_err   = pend_ff;
               mode_in = MODE_IDLE;
               pend_in = '0;
            end
            // char literal body
            MODE_CHAR: begin
               pos_in = pos_inc;
               len_in = len_grow;
               if (c == "'") begin
                  a_valid = 1'b1;
                  a_kind  = KIND_CHAR;
                  a_len   = len_grow;
                  a_err   = pend_ff;
                  if ({1'b0, len_grow} > CHAR_LIMIT) a_err = a_err | ERR_CHAR_LONG;
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end
            end
            default: begin
               mode_in   = MODE_IDLE;
               scan_byte = 1'b1;
            end
         endcase

         // byte seen between tokens
         if (scan_byte) begin
            if (c inside {" ", [8'd9:8'd13]}) begin
               if (c == "\n" && line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
               pos_in  = pos_inc;
               mode_in = MODE_IDLE;
            end else begin
               start_in = pos_ff;
               pos_in   = pos_inc;
               len_in   = 16'd1;
               pend_in  = '0;
               mode_in  = MODE_IDLE;
               b_start  = pos16;
               b_len    = 16'd1;
               case (c)
                  "(": begin b_valid = 1'b1; b_kind = KIND_LPAREN;   end
                  ")": begin b_valid = 1'b1; b_kind = KIND_RPAREN;   end
                  "{": begin b_valid = 1'b1; b_kind = KIND_LBRACE;   end
                  "}": begin b_valid = 1'b1; b_kind = KIND_RBRACE;   end
                  "]": begin b_valid = 1'b1; b_kind = KIND_RBRACKET; end
                  ",": begin b_valid = 1'b1; b_kind = KIND_COMMA;    end
                  "*": begin b_valid = 1'b1; b_kind = KIND_STAR;     end
                  ";": begin b_valid = 1'b1; b_kind = KIND_SEMI;     end
                  "&": begin b_valid = 1'b1; b_kind = KIND_AMP;      end
                  ".": begin b_valid = 1'b1; b_kind = KIND_DOT;      end
                  "[", "<", ">", "!", "=", "+", "-", "/": begin
                     lead_in = c;
                     mode_in = MODE_LOOK;
                  end
                  "\"": mode_in = MODE_STRING;
                  "'":  mode_in = MODE_CHAR;
                  default: begin
                     b_valid = 1'b1;
                     b_kind  = KIND_UNKNOWN;
                     b_err   = ERR_UNKNOWN;
                  end
               endcase
            end
         end
      end
   end

   // sticky error flag as seen by each token in turn
   assign seen_a  = seen_ff | (a_valid && a_err != 5'd0);
   assign seen_in = seen_a | (b_valid && b_err != 5'd0);

   // pack the tokens, flushed token first
   always_comb begin
      rsp_a.token_kind    = a_kind;
      rsp_a.lexeme_start  = start16;
      rsp_a.lexeme_length = a_len;
      rsp_a.line_number   = line_ff;
      rsp_a.error_bits    = a_err;
      rsp_a.any_error     = seen_a;
      rsp_a.last_of_run   = !b_valid;
      rsp_b.token_kind    = b_kind;
      rsp_b.lexeme_start  = b_start;
      rsp_b.lexeme_length = b_len;
      rsp_b.line_number   = line_ff;
      rsp_b.error_bits    = b_err;
      rsp_b.any_error     = seen_in;
      rsp_b.last_of_run   = 1'b1;
      burst.count         = {1'b0, a_valid} + {1'b0, b_valid};
      burst.first         = a_valid ? rsp_a : rsp_b;
      burst.second        = rsp_b;
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         lead_ff  <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         line_ff  <= '0;
         seen_ff  <= 1'b0;
         pend_ff  <= '0;
         len_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         lead_ff  <= lead_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         line_ff  <= line_in;
         seen_ff  <= seen_in;
         pend_ff  <= pend_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ===== hw/rtl/stsc_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// stsc_rsp_queue: four-entry response queue
// Takes a burst of up to two tokens per cycle and hands them out one per
// cycle while popped; reports room whenever a full burst still fits.
// ----------------------------------------------------------------------------
module stsc_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stsc_pkg::burst_type burst,
   input  logic                pop,
   output logic                has_space,
   output logic                out_valid,
   output stsc_pkg::rsp_type   out_data
);
   import stsc_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_type          mem [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] push_n;
   logic [PTR_W-1:0] wr_next;

   // pointer and occupancy bookkeeping
   assign push_n    = push ? CNT_W'(burst.count) : '0;
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + push_n - CNT_W'(pop);
   assign has_space = count_ff <= CNT_W'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push && burst.count != 2'd0) mem[wr_ptr_ff] <= burst.first;
      if (push && burst.count == 2'd2) mem[wr_next] <= burst.second;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner: byte-stream lexical scanner
// Each request carries one source byte, or an end marker. The scanner skips
// whitespace, counts newlines seen between tokens, and emits punctuation,
// two-character operators, line comments, string and char literal tokens,
// with start offset, length, line and error flags.
//
// Channels: req_ (valid/ready, one byte or end marker per request) and
// rsp_ (valid/ready, one token per transfer). A request causes zero, one
// or two tokens; last_of_run marks the final token of a request, and an
// end marker always ends with an EOF token.
// Tokens are registered in the response queue and leave rsp_ in request order.
// Throughput: one request per cycle while the scanner emits at most one
// token per request and rsp_ready holds high; the single rsp_ port sets
// the pace when requests yield two tokens. A four-entry response queue
// takes up to two tokens a cycle; req_ready stays high while two entries
// are free, so requests flow on while tokens wait on a stalled receiver.
// Reset: synchronous; clears the scan state, line count, error flag and the
// response queue. No clearing pass is needed.
// ----------------------------------------------------------------------------
module source_token_scanner #(
   parameter int unsigned POSITION_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stsc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stsc_pkg::rsp_type rsp_payload
);
   import stsc_pkg::*;

   logic      step;
   logic      pop;
   burst_type burst;

   // handshakes
   assign step = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;

   // scanner state and token logic
   stsc_lexer #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .step (step),
      .req  (req_payload),
      .burst(burst)
   );

   // response queue
   stsc_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (step),
      .burst    (burst),
      .pop      (pop),
      .has_space(req_ready),
      .out_valid(rsp_valid),
      .out_data (rsp_payload)
   );

   // an end marker always closes its run with an EOF token
   assert property (@(posedge clock) disable iff (reset)
      step && req_payload.source_end |->
         (burst.count == 2'd2 && burst.second.token_kind == KIND_EOF) ||
         (burst.count == 2'd1 && burst.first.token_kind == KIND_EOF))
      else $error("end marker without closing eof token");

   // a two-token burst marks only its second token as last
   assert property (@(posedge clock) disable iff (reset)
      burst.count == 2'd2 |-> burst.second.last_of_run && !burst.first.last_of_run)
      else $error("last_of_run misplaced in two-token burst");

   // a queue with no room for a burst always has a token to offer
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty response queue");

   // the queue only drains by handing tokens out
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) && !$past(reset) |-> $past(rsp_ready))
      else $error("response dropped without a transfer");

endmodule

// ===== tb/tb_source_token_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_token_scanner: self-checking bench for the source token scanner
// A short directed stimulus table covers reset values, byte extremes, every
// scan mode and each error flag. A long random byte stream of mostly
// well-formed fragments follows. A local lexer model predicts the tokens,
// typed table rows give their own, and the monitor compares the tokens
// field by field. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_source_token_scanner;
   import stsc_pkg::*;

   localparam logic [4:0] NO_ERRORS = 5'b00000;
   localparam int unsigned RANDOM_REQUESTS = 950;
   localparam int unsigned CALM_TAIL = 150;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_LOOK, SCAN_COMMENT, SCAN_STRING, SCAN_STRTAIL, SCAN_CHAR
   } scan_state_type;

   typedef struct {
      req_type item;
      bit      typed_row;
      rsp_type token;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   // lexer model state
   scan_state_type lx_mode;
   logic [7:0]     lx_lead;
   logic [15:0]    lx_pos;
   logic [15:0]    lx_start;
   logic [15:0]    lx_line;
   logic [15:0]    lx_len;
   logic           lx_err_seen;
   logic [4:0]     lx_pend;

   rsp_type          step_tokens[$];
   rsp_type          pending_tokens[$];
   req_type          source_queue[$];
   directed_row_type directed_rows[$];

   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;
   bit          calm_phase = 1'b0;
   bit          receiver_bursty = 1'b0;
   bit          sender_bursty = 1'b0;

   string punct_chars = "(){}],*;&.";
   string pair_chars  = "[]<=>=!===++--";
   string lead_chars  = "[<>!=+-/";

   source_token_scanner uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // lexer model
   // ------------------------------------------------------------------------

   function automatic logic [4:0] lone_kind(input logic [7:0] lead);
      case (lead)
         "[":     return KIND_LBRACKET;
         "<":     return KIND_LESS;
         ">":     return KIND_GREATER;
         "!":     return KIND_BANG;
         "=":     return KIND_EQ;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         default: return KIND_SLASH;
      endcase
   endfunction

   // KIND_EOF means the two bytes do not pair up
   function automatic logic [4:0] paired_kind(input logic [7:0] lead,
                                              input logic [7:0] c);
      case (lead)
         "[":     return (c == "]") ? KIND_BRACKETS : KIND_EOF;
         "<":     return (c == "=") ? KIND_LESS_EQ : KIND_EOF;
         ">":     return (c == "=") ? KIND_GREATER_EQ : KIND_EOF;
         "!":     return (c == "=") ? KIND_BANG_EQ : KIND_EOF;
         "=":     return (c == "=") ? KIND_EQ_EQ : KIND_EOF;
         "+":     return (c == "+") ? KIND_PLUS_PLUS : KIND_EOF;
         "-":     return (c == "-") ? KIND_MINUS_MINUS : KIND_EOF;
         "/":     return (c == "/") ? KIND_COMMENT : KIND_EOF;
         default: return KIND_EOF;
      endcase
   endfunction

   function automatic void lex_put(input logic [4:0] kind, input logic [15:0] start,
                                   input logic [15:0] len, input logic [4:0] errs);
      rsp_type t;
      if (errs != NO_ERRORS) lx_err_seen = 1'b1;
      t.token_kind    = kind;
      t.lexeme_start  = start;
      t.lexeme_length = len;
      t.line_number   = lx_line;
      t.error_bits    = errs;
      t.any_error     = lx_err_seen;
      t.last_of_run   = 1'b0;
      step_tokens = {step_tokens, t};
   endfunction

   function automatic void lex_emit(input logic [4:0] kind, input logic [4:0] errs);
      lex_put(kind, lx_start, lx_len, errs);
      lx_mode = SCAN_IDLE;
      lx_pend = NO_ERRORS;
   endfunction

   // byte joins the token in progress
   function automatic void lex_consume();
      lx_pos = lx_pos + 16'd1;
      if (lx_len != 16'hFFFF) lx_len = lx_len + 16'd1;
   endfunction

   // byte seen between tokens
   function automatic void lex_fresh_byte(input logic [7:0] c);
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         if (c == "\n" && lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
         lx_pos = lx_pos + 16'd1;
         return;
      end
      lx_start = lx_pos;
      lx_pos   = lx_pos + 16'd1;
      lx_len   = 16'd1;
      lx_pend  = NO_ERRORS;
      case (c)
         "(": lex_emit(KIND_LPAREN, NO_ERRORS);
         ")": lex_emit(KIND_RPAREN, NO_ERRORS);
         "{": lex_emit(KIND_LBRACE, NO_ERRORS);
         "}": lex_emit(KIND_RBRACE, NO_ERRORS);
         "]": lex_emit(KIND_RBRACKET, NO_ERRORS);
         ",": lex_emit(KIND_COMMA, NO_ERRORS);
         "*": lex_emit(KIND_STAR, NO_ERRORS);
         ";": lex_emit(KIND_SEMI, NO_ERRORS);
         "&": lex_emit(KIND_AMP, NO_ERRORS);
         ".": lex_emit(KIND_DOT, NO_ERRORS);
         "[", "<", ">", "!", "=", "+", "-", "/": begin
            lx_lead = c;
            lx_mode = SCAN_LOOK;
         end
         "\"": lx_mode = SCAN_STRING;
         "'": lx_mode = SCAN_CHAR;
         default: lex_emit(KIND_UNKNOWN, ERR_UNKNOWN);
      endcase
   endfunction

   // tokens caused by one request, left in step_tokens
   function automatic void lex_step(input req_type r);
      logic [4:0] kind;
      logic [4:0] errs;
      step_tokens.delete();
      if (r.source_end) begin
         // flush the token in progress, then EOF
         case (lx_mode)
            SCAN_LOOK:    lex_emit(lone_kind(lx_lead), NO_ERRORS);
            SCAN_COMMENT: lex_emit(KIND_COMMENT, NO_ERRORS);
            SCAN_STRING, SCAN_STRTAIL:
               lex_emit(KIND_STRING, lx_pend | ERR_UNTERM_STRING);
            SCAN_CHAR: begin
               errs = lx_pend | ERR_UNTERM_CHAR;
               if ({1'b0, lx_len} + 17'd1 > CHAR_LIMIT) errs |= ERR_CHAR_LONG;
               lex_emit(KIND_CHAR, errs);
            end
            default: ;
         endcase
         lx_mode = SCAN_IDLE;
         lex_put(KIND_EOF, lx_pos, 16'd0, NO_ERRORS);
      end else begin
         case (lx_mode)
            SCAN_LOOK: begin
               kind = paired_kind(lx_lead, r.source_char);
               if (kind == KIND_COMMENT) begin
                  lex_consume();
                  lx_mode = SCAN_COMMENT;
               end else if (kind != KIND_EOF) begin
                  lex_consume();
                  lex_emit(kind, NO_ERRORS);
               end else begin
                  lex_emit(lone_kind(lx_lead), NO_ERRORS);
                  lex_fresh_byte(r.source_char);
               end
            end
            SCAN_COMMENT: begin
               if (r.source_char == "\n") begin
                  lex_emit(KIND_COMMENT, NO_ERRORS);
                  lex_fresh_byte(r.source_char);
               end else begin
                  lex_consume();
               end
            end
            SCAN_STRING: begin
               lex_consume();
               if (r.source_char == "\"") begin
                  lex_emit(KIND_STRING, lx_pend);
               end else if (r.source_char == "\n") begin
                  lx_pend |= ERR_MULTILINE;
                  lx_mode = SCAN_STRTAIL;
               end
            end
            SCAN_STRTAIL: begin
               lex_consume();
               lex_emit(KIND_STRING, lx_pend);
            end
            SCAN_CHAR: begin
               lex_consume();
               if (r.source_char == "'") begin
                  errs = lx_pend;
                  if ({1'b0, lx_len} > CHAR_LIMIT) errs |= ERR_CHAR_LONG;
                  lex_emit(KIND_CHAR, errs);
               end
            end
            default: lex_fresh_byte(r.source_char);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type make_request(input logic [7:0] c, input logic e);
      req_type r;
      r.source_char = c;
      r.source_end  = e;
      return r;
   endfunction

   // token that ends its request
   function automatic rsp_type known_token(input logic [4:0] kind,
                                           input logic [15:0] start,
                                           input logic [15:0] len,
                                           input logic [15:0] line,
                                           input logic [4:0] errs,
                                           input logic any);
      rsp_type t;
      t.token_kind    = kind;
      t.lexeme_start  = start;
      t.lexeme_length = len;
      t.line_number   = line;
      t.error_bits    = errs;
      t.any_error     = any;
      t.last_of_run   = 1'b1;
      return t;
   endfunction

   function automatic void add_row(input logic [7:0] c, input logic e,
                                   input bit typed_row, input rsp_type token);
      directed_row_type row;
      row.item      = make_request(c, e);
      row.typed_row = typed_row;
      row.token     = token;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void push_source(input logic [7:0] c, input logic e);
      source_queue = {source_queue, make_request(c, e)};
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] ex_a,
                                             input logic [7:0] ex_b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == ex_a || c == ex_b);
      return c;
   endfunction

   // random source text, mostly well-formed token fragments
   function automatic void compose_source(input int unsigned target);
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      while (source_queue.size() < target) begin
         pick = $urandom_range(0, 19);
         case (pick)
            0, 1, 17: begin
               n = $urandom_range(0, 5);
               push_source((n == 0) ? 8'h20 : 8'(8 + n), 1'b0);
            end
            2, 3, 4: push_source(punct_chars[$urandom_range(0, 9)], 1'b0);
            5, 6: begin
               k = 2 * $urandom_range(0, 6);
               push_source(pair_chars[k], 1'b0);
               push_source(pair_chars[k + 1], 1'b0);
            end
            7, 18: push_source(lead_chars[$urandom_range(0, 7)], 1'b0);
            8: begin
               // line comment, sometimes left open
               push_source("/", 1'b0);
               push_source("/", 1'b0);
               n = $urandom_range(0, 8);
               repeat (n) push_source(other_byte("\n", "\n"), 1'b0);
               if ($urandom_range(0, 4) != 0) push_source("\n", 1'b0);
            end
            9, 10: begin
               push_source("\"", 1'b0);
               n = $urandom_range(0, 6);
               repeat (n) push_source(other_byte("\"", "\n"), 1'b0);
               if ($urandom_range(0, 5) == 0) begin
                  push_source("\n", 1'b0);
                  push_source(8'($urandom_range(0, 255)), 1'b0);
               end else if ($urandom_range(0, 9) != 0) begin
                  push_source("\"", 1'b0);
               end
            end
            11, 12: begin
               push_source("'", 1'b0);
               n = $urandom_range(0, 3);
               repeat (n) push_source(other_byte("'", "'"), 1'b0);
               if ($urandom_range(0, 7) != 0) push_source("'", 1'b0);
            end
            13, 14: push_source(8'($urandom_range(0, 255)), 1'b0);
            15: begin
               push_source("/", 1'b0);
               push_source(other_byte("/", "/"), 1'b0);
            end
            16: push_source(8'($urandom_range(0, 255)), 1'b1);
            default: push_source("\n", 1'b0);
         endcase
      end
      push_source(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------

   task automatic offer_request(input req_type item, input bit typed_row,
                                input rsp_type token);
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lex_step(item);
      if (typed_row) begin
         pending_tokens = {pending_tokens, token};
      end else begin
         foreach (step_tokens[j]) pending_tokens = {pending_tokens, step_tokens[j]};
      end
   endtask

   // hold requests until every predicted token has come out
   task automatic drain_tokens();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // token checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string field, input int unsigned got,
                                input int unsigned want);
      mismatches++;
      $display("token mismatch on %s: got %0d, expected %0d at %0t",
               field, got, want, $realtime);
   endtask

   always @(posedge clock) begin : token_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            flag_mismatch("unexpected token kind", rsp_payload.token_kind, 0);
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_payload.token_kind !== want.token_kind)
               flag_mismatch("token_kind", rsp_payload.token_kind, want.token_kind);
            if (rsp_payload.lexeme_start !== want.lexeme_start)
               flag_mismatch("lexeme_start", rsp_payload.lexeme_start,
                             want.lexeme_start);
            if (rsp_payload.lexeme_length !== want.lexeme_length)
               flag_mismatch("lexeme_length", rsp_payload.lexeme_length,
                             want.lexeme_length);
            if (rsp_payload.line_number !== want.line_number)
               flag_mismatch("line_number", rsp_payload.line_number,
                             want.line_number);
            if (rsp_payload.error_bits !== want.error_bits)
               flag_mismatch("error_bits", rsp_payload.error_bits, want.error_bits);
            if (rsp_payload.any_error !== want.any_error)
               flag_mismatch("any_error", rsp_payload.any_error, want.any_error);
            if (rsp_payload.last_of_run !== want.last_of_run)
               flag_mismatch("last_of_run", rsp_payload.last_of_run,
                             want.last_of_run);
         end
      end
   end

   // receiver stalls in bursts, quiet stretches in between
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_cycles != 0) begin
         stall_cycles = stall_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 59) == 0) receiver_bursty = !receiver_bursty;
         if (!calm_phase && receiver_bursty && $urandom_range(0, 5) == 0) begin
            stall_cycles = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin : stimulus
      int unsigned total;
      rsp_type     none;
      none        = '0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      lx_mode     = SCAN_IDLE;
      lx_lead     = 8'h00;
      lx_pos      = 16'd0;
      lx_start    = 16'd0;
      lx_line     = 16'd0;
      lx_len      = 16'd0;
      lx_err_seen = 1'b0;
      lx_pend     = NO_ERRORS;

      // directed table
      add_row("(", 1'b0, 1'b1,
              known_token(KIND_LPAREN, 16'd0, 16'd1, 16'd0, NO_ERRORS, 1'b0));
      add_row(")", 1'b0, 1'b0, none);
      add_row("\n", 1'b0, 1'b0, none);
      add_row(8'h00, 1'b0, 1'b1,
              known_token(KIND_UNKNOWN, 16'd3, 16'd1, 16'd1, ERR_UNKNOWN, 1'b1));
      add_row(8'hFF, 1'b0, 1'b0, none);
      add_row("[", 1'b0, 1'b0, none);
      add_row("]", 1'b0, 1'b0, none);
      add_row("<", 1'b0, 1'b0, none);
      add_row("=", 1'b0, 1'b0, none);
      // lone lookahead followed by a token gives two results
      add_row(">", 1'b0, 1'b0, none);
      add_row("{", 1'b0, 1'b0, none);
      // line comment closed by a newline
      add_row("/", 1'b0, 1'b0, none);
      add_row("/", 1'b0, 1'b0, none);
      add_row(8'h80, 1'b0, 1'b0, none);
      add_row("\n", 1'b0, 1'b0, none);
      // string with a newline inside
      add_row("\"", 1'b0, 1'b0, none);
      add_row("\n", 1'b0, 1'b0, none);
      add_row("\"", 1'b0, 1'b0, none);
      // char literal too long and cut off by the end marker
      add_row("'", 1'b0, 1'b0, none);
      add_row("a", 1'b0, 1'b0, none);
      add_row("b", 1'b0, 1'b0, none);
      add_row(8'hFF, 1'b1, 1'b0, none);
      // lone slash at end, then a bare end marker
      add_row("/", 1'b0, 1'b0, none);
      add_row(8'h00, 1'b1, 1'b0, none);
      add_row(8'h00, 1'b1, 1'b1,
              known_token(KIND_EOF, 16'd22, 16'd0, 16'd2, NO_ERRORS, 1'b1));
      // unterminated string
      add_row("\"", 1'b0, 1'b0, none);
      add_row(8'h00, 1'b1, 1'b0, none);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].item, directed_rows[i].typed_row,
                       directed_rows[i].token);
      drain_tokens();

      // random source stream
      compose_source(RANDOM_REQUESTS);
      total = source_queue.size();
      for (int unsigned i = 0; i < total; i++) begin
         calm_phase = (i + CALM_TAIL >= total);
         if (i == total / 2) drain_tokens();
         if (!calm_phase) begin
            if ($urandom_range(0, 39) == 0) sender_bursty = !sender_bursty;
            if (sender_bursty && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
         end
         offer_request(source_queue[i], 1'b0, none);
      end

      drain_tokens();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("timeout with %0d tokens outstanding", pending_tokens.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
